FILE: sv/sphd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// sphd_pkg
// Shared types and constants for the switch press/hold debouncer.
// ============================================================================
package sphd_pkg;

    // Width of the switch level and event mask fields
    localparam int unsigned MASK_W = 8;
    localparam int unsigned NUM_SWITCHES_DEF = 8;

    // Threshold register width and reset values
    localparam int unsigned THR_W = 8;
    localparam logic [THR_W-1:0] PRESS_THR_RST = 8'd6;
    localparam logic [THR_W-1:0] HOLD_THR_RST = 8'd50;

    // Sample counters saturate at the top of their range
    localparam int unsigned CNT_W = 9;
    localparam logic [CNT_W-1:0] CNT_MAX = 9'd511;

    // Debounce phase codes
    localparam logic [1:0] PH_RELEASED = 2'd0;
    localparam logic [1:0] PH_PRESSED = 2'd1;
    localparam logic [1:0] PH_HOLD = 2'd2;
    localparam logic [1:0] PH_HOLDING = 2'd3;

    // Configuration port
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam logic REG_PRESS_THR = 1'b0;
    localparam logic REG_HOLD_THR = 1'b1;

    // What one lane reports for the current tick
    typedef struct packed {
        logic press_ev;
        logic hold_ev;
        logic rel_ev;
        logic closed;
    } lane_evt_t;

    // One result item
    typedef struct packed {
        logic [MASK_W-1:0] pressed;
        logic [MASK_W-1:0] held;
        logic [MASK_W-1:0] released;
        logic [MASK_W-1:0] closed;
    } result_t;

endpackage

FILE: sv/sphd_lane.sv
`timescale 1ns / 1ps
// ============================================================================
// sphd_lane
// Debouncer for one switch: phase register plus closed and open counters.
// ============================================================================
module sphd_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          level,
    input  logic [sphd_pkg::THR_W-1:0]    press_thr,
    input  logic [sphd_pkg::THR_W-1:0]    hold_thr,
    output sphd_pkg::lane_evt_t           evt
);
    import sphd_pkg::*;

    logic [1:0]       phase_reg;
    logic [1:0]       phase_next;
    logic [CNT_W-1:0] closed_cnt_reg;
    logic [CNT_W-1:0] closed_cnt_next;
    logic [CNT_W-1:0] open_cnt_reg;
    logic [CNT_W-1:0] open_cnt_next;
    logic [CNT_W-1:0] closed_inc;
    logic [CNT_W-1:0] open_inc;

    assign closed_inc = (closed_cnt_reg == CNT_MAX) ? closed_cnt_reg
                                                     : CNT_W'(closed_cnt_reg + 1'b1);
    assign open_inc   = (open_cnt_reg == CNT_MAX) ? open_cnt_reg
                                                   : CNT_W'(open_cnt_reg + 1'b1);

    always_comb
    begin
        phase_next      = phase_reg;
        closed_cnt_next = closed_cnt_reg;
        open_cnt_next   = open_cnt_reg;
        evt             = '0;
        if (level)
        begin
            unique case (phase_reg)
                PH_RELEASED:
                begin
                    phase_next = PH_PRESSED;
                end
                PH_PRESSED:
                begin
                    closed_cnt_next = closed_inc;
                    if (closed_inc > {1'b0, press_thr})
                    begin
                        phase_next   = PH_HOLD;
                        evt.press_ev = 1'b1;
                    end
                end
                PH_HOLD:
                begin
                    closed_cnt_next = closed_inc;
                    if (closed_inc > {1'b0, hold_thr})
                    begin
                        phase_next  = PH_HOLDING;
                        evt.hold_ev = 1'b1;
                    end
                end
                PH_HOLDING:
                begin
                    phase_next = PH_HOLDING;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
        else if (phase_reg[1])
        begin
            // hold or holding: count open samples towards release
            open_cnt_next = open_inc;
            if (open_inc > {1'b0, press_thr})
            begin
                phase_next = PH_RELEASED;
                evt.rel_ev = 1'b1;
            end
        end
        if (evt.press_ev || evt.hold_ev || evt.rel_ev)
        begin
            closed_cnt_next = '0;
            open_cnt_next   = '0;
        end
        evt.closed = phase_next[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_RELEASED;
            closed_cnt_reg <= '0;
            open_cnt_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            closed_cnt_reg <= closed_cnt_next;
            open_cnt_reg   <= open_cnt_next;
        end
    end

endmodule

FILE: sv/sphd_merge.sv
`timescale 1ns / 1ps
// ============================================================================
// sphd_merge
// Gathers lane reports into the four masks and holds them in a two-entry
// output queue.
// ============================================================================
module sphd_merge #(
    parameter int unsigned NUM_SWITCHES = sphd_pkg::NUM_SWITCHES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sphd_pkg::lane_evt_t            lane_evt [NUM_SWITCHES],
    input  logic                           push,
    input  logic                           pop,
    output logic                           full,
    output logic                           not_empty,
    output sphd_pkg::result_t              head
);
    import sphd_pkg::*;

    result_t    merged;
    result_t    q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    // Lanes past the mask width are dropped; mask bits with no lane stay low
    for (genvar j = 0; j < MASK_W; j++)
    begin : g_bit
        if (j < NUM_SWITCHES)
        begin : g_lane
            assign merged.pressed[j]  = lane_evt[j].press_ev;
            assign merged.held[j]     = lane_evt[j].hold_ev;
            assign merged.released[j] = lane_evt[j].rel_ev;
            assign merged.closed[j]   = lane_evt[j].closed;
        end
        else
        begin : g_none
            assign merged.pressed[j]  = 1'b0;
            assign merged.held[j]     = 1'b0;
            assign merged.released[j] = 1'b0;
            assign merged.closed[j]   = 1'b0;
        end
    end

    assign full        = (count_reg == 2'd2);
    assign not_empty   = (count_reg != 2'd0);
    assign head        = q_reg[rd_ptr_reg];
    assign wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
    assign count_next  = 2'(count_reg + {1'b0, push} - {1'b0, pop});

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= merged;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: sv/switch_press_hold_debouncer.sv
`timescale 1ns / 1ps
// ============================================================================
// switch_press_hold_debouncer
// Press/hold/release debouncer for a bank of switches, one lane per switch.
// ============================================================================
//
//  Channel  Signals                                   Moves
//  -------  ----------------------------------------  ---------------------------
//  in       in_valid / in_ready, switch_levels        one scan tick per item
//  out      out_valid / out_ready, *_mask             event and state masks
//  cfg      psel penable pwrite paddr pwdata prdata   thresholds, APB, no waits
//
//  One item per clock while ready. Every lane updates its switch in the cycle
//  the item is accepted; the result is in the output queue the cycle after.
//  The two-entry output queue sets the stall behaviour: in_ready drops only
//  while two result items wait, so one waiting result does not hold up input.
//  Reset (rst_n low, asynchronous) puts every switch in released with zeroed
//  counters, empties the queue and restores the thresholds to 6 and 50.
//  Threshold writes apply from the next accepted item onwards.
//
module switch_press_hold_debouncer #(
    parameter int unsigned NUM_SWITCHES = sphd_pkg::NUM_SWITCHES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // scan tick input
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [sphd_pkg::MASK_W-1:0]     switch_levels,
    // result output
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sphd_pkg::MASK_W-1:0]     pressed_mask,
    output logic [sphd_pkg::MASK_W-1:0]     held_mask,
    output logic [sphd_pkg::MASK_W-1:0]     released_mask,
    output logic [sphd_pkg::MASK_W-1:0]     closed_mask,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sphd_pkg::PADDR_W-1:0]    paddr,
    input  logic [sphd_pkg::PDATA_W-1:0]    pwdata,
    output logic [sphd_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);
    import sphd_pkg::*;

    logic [THR_W-1:0] press_thr_reg;
    logic [THR_W-1:0] hold_thr_reg;
    logic             cfg_wr;
    logic             step;
    logic             q_full;
    result_t          head;
    lane_evt_t        lane_evt [NUM_SWITCHES];

    // ------------------------------------------------------------------
    // Configuration registers: word 0 press threshold, word 1 hold
    // threshold. Only the low byte of the write data is kept.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_thr_reg <= PRESS_THR_RST;
            hold_thr_reg  <= HOLD_THR_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_PRESS_THR)
            begin
                press_thr_reg <= pwdata[THR_W-1:0];
            end
            else
            begin
                hold_thr_reg <= pwdata[THR_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_HOLD_THR) ? {{(PDATA_W-THR_W){1'b0}}, hold_thr_reg}
                                               : {{(PDATA_W-THR_W){1'b0}}, press_thr_reg};

    // ------------------------------------------------------------------
    // Handshake: accept while the output queue has a free entry.
    // ------------------------------------------------------------------
    assign in_ready = !q_full;
    assign step     = in_valid && in_ready;

    // ------------------------------------------------------------------
    // One lane per switch. Lanes with no level bit always see open and so
    // never leave released.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < NUM_SWITCHES; i++)
    begin : g_lane
        logic lvl;
        if (i < MASK_W)
        begin : g_in
            assign lvl = switch_levels[i];
        end
        else
        begin : g_open
            assign lvl = 1'b0;
        end

        sphd_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (step),
            .level     (lvl),
            .press_thr (press_thr_reg),
            .hold_thr  (hold_thr_reg),
            .evt       (lane_evt[i])
        );
    end

    // ------------------------------------------------------------------
    // Merge lane reports into masks and queue the result item.
    // ------------------------------------------------------------------
    sphd_merge #(
        .NUM_SWITCHES (NUM_SWITCHES)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .lane_evt  (lane_evt),
        .push      (step),
        .pop       (out_valid && out_ready),
        .full      (q_full),
        .not_empty (out_valid),
        .head      (head)
    );

    assign pressed_mask  = head.pressed;
    assign held_mask     = head.held;
    assign released_mask = head.released;
    assign closed_mask   = head.closed;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------

    // input is only refused while results are waiting
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("in_ready low with no result waiting");

    // an accepted item always leaves a result behind it
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid)
        else $error("accepted item left no result");

    // a switch gives at most one event per tick
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (((pressed_mask & held_mask) == '0)
                    && ((pressed_mask & released_mask) == '0)
                    && ((held_mask & released_mask) == '0)))
        else $error("more than one event for a switch");

    // press and hold land in a closed phase, release in an open one
    a_event_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((((pressed_mask | held_mask) & ~closed_mask) == '0)
                    && ((released_mask & closed_mask) == '0)))
        else $error("event mask disagrees with debounced state");

endmodule
